// ===== rtl/fdsa_pkg.sv =====
// Shared constants and command codes of the Forth data stack with arithmetic unit.
// No dependencies; imported by forth_data_stack_alu.
package fdsa_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 64;
    localparam int CMD_W       = 4;
    localparam int DEPTH_W     = 5;
    localparam int FLAG_W      = 3;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(DATA_W);
    localparam int S_TDATA_W   = ((CMD_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DATA_W + DEPTH_W + FLAG_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 4'd0,
        CMD_ADD  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_MUL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_DUP  = 4'd5,
        CMD_SWAP = 4'd6,
        CMD_DROP = 4'd7,
        CMD_PICK = 4'd8,
        CMD_GT   = 4'd9,
        CMD_GE   = 4'd10,
        CMD_LT   = 4'd11,
        CMD_LE   = 4'd12,
        CMD_EQ   = 4'd13,
        CMD_NE   = 4'd14,
        CMD_NOP  = 4'd15
    } cmd_t;

endpackage

// ===== rtl/forth_data_stack_alu.sv =====
// Forth data stack with a shared 64-bit add/subtract unit and a small sequencer.
// Depends on fdsa_pkg (constants, command codes).
//
// Channel  Dir  Handshake           Fields (tdata, low bit first)
// s_*      in   s_tvalid/s_tready   cmd[3:0], literal[67:4], zero pad to 72
// m_*      out  m_tvalid/m_tready   top_value[63:0], depth[68:64], underflow[69],
//                                   overflow[70], divide_by_zero[71]
//
// Flow: one word at a time; s_tready is high only when the sequencer idles.
// Mul runs 64 shift-add steps, div two negates, 64 restoring steps and a
// fixup; dup of an empty stack and swap make two writes. All of that
// sequencing is set by the single adder and the stack memory, which has one
// write port and one registered read port.
// Reset: rst_n clears the sequencer, the depth count and the output valid;
// stack cells stay unknown until pushed; reads above the depth are never used.
// Stalls: a finished result waits in the output register while the next word
// is accepted; the sequencer holds in its final state if that register is full.
module forth_data_stack_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd[3:0], literal[67:4], zero pad
    input  logic [fdsa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // top_value[63:0], depth[68:64], underflow, overflow, divide_by_zero
    output logic [fdsa_pkg::M_TDATA_W-1:0] m_tdata
);

    import fdsa_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD_B   = 13'b0000000000010,
        ST_RD_A   = 13'b0000000000100,
        ST_OP     = 13'b0000000001000,
        ST_MUL    = 13'b0000000010000,
        ST_NEG_A  = 13'b0000000100000,
        ST_NEG_B  = 13'b0000001000000,
        ST_DIV    = 13'b0000010000000,
        ST_FIX    = 13'b0000100000000,
        ST_WR     = 13'b0001000000000,
        ST_WR2    = 13'b0010000000000,
        ST_RD_TOP = 13'b0100000000000,
        ST_TOP    = 13'b1000000000000
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Payload / working registers
    cmd_t                   cmd_reg, cmd_next;
    logic [DATA_W-1:0]      lit_reg, lit_next;
    logic [DATA_W-1:0]      a_reg, a_next;        // operand a, multiplicand, quotient
    logic [DATA_W-1:0]      b_reg, b_next;        // operand b, multiplier, divisor
    logic [DATA_W-1:0]      acc_reg, acc_next;    // result, product, remainder
    logic [PTR_W-1:0]       idx_reg, idx_next;    // address of a second write
    logic [ITER_W-1:0]      cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   unf_reg, unf_next;
    logic                   ovf_reg, ovf_next;
    logic                   dz_reg, dz_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Stack memory: one write and one registered read per cycle
    logic [DATA_W-1:0]      mem [0:STACK_DEPTH-1];
    logic [DATA_W-1:0]      rd_data_reg;
    logic [PTR_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [PTR_W-1:0]       wr_addr;
    logic [DATA_W-1:0]      wr_data;

    // Shared adder
    logic [DATA_W-1:0]      add_x, add_y;
    logic                   add_sub;
    logic [DATA_W:0]        add_sum;
    logic                   add_carry;

    // Stack pointers and decode
    logic [CNT_W-1:0]       depth_m1, depth_m2;
    logic [PTR_W-1:0]       top_idx, next_idx, pick_idx;
    logic                   have_b, have_a, is_full, is_binary;
    logic [DATA_W-1:0]      a_val;
    logic [DATA_W-1:0]      rem_shift;
    logic                   cmp_ovf, cmp_lt, cmp_eq, cmp_bit;

    assign depth_m1  = depth_reg - CNT_W'(1);
    assign depth_m2  = depth_reg - CNT_W'(2);
    assign top_idx   = depth_m1[PTR_W-1:0];
    assign next_idx  = depth_m2[PTR_W-1:0];
    // cell n below the top once n is popped: depth - 2 - n (only used when in range)
    assign pick_idx  = PTR_W'(depth_m2 - rd_data_reg[CNT_W-1:0]);
    assign have_b    = (depth_reg != '0);
    assign have_a    = (depth_reg >= CNT_W'(2));
    assign is_full   = (depth_reg == CNT_W'(STACK_DEPTH));
    assign is_binary = (cmd_reg inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT,
                                        CMD_GE, CMD_LT, CMD_LE, CMD_EQ, CMD_NE});
    // second operand comes straight from the read port in the operate cycle
    assign a_val     = have_a ? rd_data_reg : '0;
    assign rem_shift = {acc_reg[DATA_W-2:0], a_reg[DATA_W-1]};

    assign add_sum   = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}}
                     + (DATA_W+1)'(add_sub);
    assign add_carry = add_sum[DATA_W];

    // Signed compare of a - b: sign of the difference corrected for overflow
    assign cmp_ovf = (a_val[DATA_W-1] != b_reg[DATA_W-1]) &&
                     (add_sum[DATA_W-1] != a_val[DATA_W-1]);
    assign cmp_lt  = add_sum[DATA_W-1] ^ cmp_ovf;
    assign cmp_eq  = (a_val == b_reg);

    always_comb
    begin
        case (cmd_reg)
            CMD_GT:  cmp_bit = !cmp_lt && !cmp_eq;
            CMD_GE:  cmp_bit = !cmp_lt;
            CMD_LT:  cmp_bit = cmp_lt;
            CMD_LE:  cmp_bit = cmp_lt || cmp_eq;
            CMD_EQ:  cmp_bit = cmp_eq;
            default: cmp_bit = !cmp_eq;
        endcase
    end

    // Adder operand select by sequencer state
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_OP:
            begin
                add_x   = a_val;
                add_y   = b_reg;
                add_sub = (cmd_reg != CMD_ADD);
            end
            ST_MUL:
            begin
                add_x = acc_reg;
                add_y = a_reg;
            end
            ST_NEG_A, ST_FIX:
            begin
                add_y   = a_reg;
                add_sub = 1'b1;
            end
            ST_NEG_B:
            begin
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            ST_DIV:
            begin
                add_x   = rem_shift;
                add_y   = b_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        cmd_next      = cmd_reg;
        lit_next      = lit_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        unf_next      = unf_reg;
        ovf_next      = ovf_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = top_idx;
        wr_en         = 1'b0;
        wr_addr       = depth_reg[PTR_W-1:0];
        wr_data       = acc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tdata[CMD_W-1:0]);
                    lit_next   = s_tdata[CMD_W +: DATA_W];
                    unf_next   = 1'b0;
                    ovf_next   = 1'b0;
                    dz_next    = 1'b0;
                    state_next = ST_RD_B;
                end
            end

            ST_RD_B:
            begin
                rd_addr    = top_idx;
                state_next = ST_RD_A;
            end

            ST_RD_A:
            begin
                // latch the top; fetch the next cell or the picked cell
                b_next     = have_b ? rd_data_reg : '0;
                rd_addr    = (cmd_reg == CMD_PICK) ? pick_idx : next_idx;
                state_next = ST_OP;
            end

            ST_OP:
            begin
                state_next = ST_RD_TOP;
                if (is_binary)
                begin
                    unf_next   = !have_a;
                    depth_next = have_a ? depth_m2 : '0;
                    a_next     = a_val;
                end
                unique case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (is_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = lit_reg;
                            depth_next = depth_reg + CNT_W'(1);
                        end
                    end
                    CMD_DUP:
                    begin
                        if (!have_b)
                        begin
                            // empty: push two zeros
                            unf_next   = 1'b1;
                            wr_en      = 1'b1;
                            wr_data    = '0;
                            a_next     = '0;
                            idx_next   = PTR_W'(1);
                            depth_next = CNT_W'(2);
                            state_next = ST_WR2;
                        end
                        else if (is_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = b_reg;
                            depth_next = depth_reg + CNT_W'(1);
                        end
                    end
                    CMD_SWAP:
                    begin
                        if (!have_a)
                        begin
                            unf_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = next_idx;
                            wr_data    = b_reg;
                            a_next     = rd_data_reg;
                            idx_next   = top_idx;
                            state_next = ST_WR2;
                        end
                    end
                    CMD_DROP:
                    begin
                        if (!have_b)
                        begin
                            unf_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_m1;
                        end
                    end
                    CMD_PICK:
                    begin
                        if (!have_b)
                        begin
                            unf_next = 1'b1;
                        end
                        else if (b_reg[DATA_W-1] || (b_reg >= DATA_W'(depth_m1)))
                        begin
                            // index out of range: n stays popped
                            unf_next   = 1'b1;
                            depth_next = depth_m1;
                        end
                        else
                        begin
                            // n popped and picked cell pushed in its place
                            wr_en   = 1'b1;
                            wr_addr = top_idx;
                            wr_data = rd_data_reg;
                        end
                    end
                    CMD_ADD, CMD_SUB:
                    begin
                        acc_next   = add_sum[DATA_W-1:0];
                        state_next = ST_WR;
                    end
                    CMD_GT, CMD_GE, CMD_LT, CMD_LE, CMD_EQ, CMD_NE:
                    begin
                        acc_next   = DATA_W'(cmp_bit);
                        state_next = ST_WR;
                    end
                    CMD_MUL:
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                    CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            dz_next    = 1'b1;
                            acc_next   = '0;
                            state_next = ST_WR;
                        end
                        else
                        begin
                            neg_next   = a_val[DATA_W-1] ^ b_reg[DATA_W-1];
                            state_next = ST_NEG_A;
                        end
                    end
                    CMD_NOP:
                    begin
                        state_next = ST_RD_TOP;
                    end
                endcase
            end

            ST_MUL:
            begin
                // shift-add, low 64 bits only
                if (b_reg[0])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                a_next   = {a_reg[DATA_W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + ITER_W'(1);
                if (cnt_reg == ITER_W'(DATA_W - 1))
                begin
                    state_next = ST_WR;
                end
            end

            ST_NEG_A:
            begin
                if (a_reg[DATA_W-1])
                begin
                    a_next = add_sum[DATA_W-1:0];
                end
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_NEG_B;
            end

            ST_NEG_B:
            begin
                if (b_reg[DATA_W-1])
                begin
                    b_next = add_sum[DATA_W-1:0];
                end
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // restoring step: carry out means no borrow
                acc_next = add_carry ? add_sum[DATA_W-1:0] : rem_shift;
                a_next   = {a_reg[DATA_W-2:0], add_carry};
                cnt_next = cnt_reg + ITER_W'(1);
                if (cnt_reg == ITER_W'(DATA_W - 1))
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                acc_next   = neg_reg ? add_sum[DATA_W-1:0] : a_reg;
                state_next = ST_WR;
            end

            ST_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = acc_reg;
                depth_next = depth_reg + CNT_W'(1);
                state_next = ST_RD_TOP;
            end

            ST_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = a_reg;
                state_next = ST_RD_TOP;
            end

            ST_RD_TOP:
            begin
                rd_addr    = top_idx;
                state_next = ST_TOP;
            end

            ST_TOP:
            begin
                // hold here until the output register frees up
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next                         = 1'b1;
                    m_tdata_next                          = '0;
                    m_tdata_next[DATA_W-1:0]              = have_b ? rd_data_reg : '0;
                    m_tdata_next[DATA_W +: DEPTH_W]       = DEPTH_W'(depth_reg);
                    m_tdata_next[DATA_W + DEPTH_W]        = unf_reg;
                    m_tdata_next[DATA_W + DEPTH_W + 1]    = ovf_reg;
                    m_tdata_next[DATA_W + DEPTH_W + 2]    = dz_reg;
                    state_next                            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        lit_reg     <= lit_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        unf_reg     <= unf_next;
        ovf_reg     <= ovf_next;
        dz_reg      <= dz_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/stack_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for forth_data_stack_alu: snoops both stream channels, runs its own stack model.
// Depends on fdsa_pkg for widths and command codes.
module stack_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // cmd[3:0], literal[67:4], zero pad
    input  logic [fdsa_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // top_value[63:0], depth[68:64], underflow, overflow, divide_by_zero
    input  logic [fdsa_pkg::M_TDATA_W-1:0] m_tdata,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);
    import fdsa_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        logic               unf;
        logic               ovf;
        logic               dz;
    } stack_result_t;

    logic [DATA_W-1:0] stack_words [STACK_DEPTH];
    int unsigned       depth_now;
    stack_result_t     awaited_results [$];
    stack_result_t     want;
    stack_result_t     got;
    int unsigned       mismatches;

    function automatic void push_cell(input logic [DATA_W-1:0] v, inout logic ovf);
        if (depth_now >= STACK_DEPTH)
            ovf = 1'b1;
        else
        begin
            stack_words[depth_now] = v;
            depth_now++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pop_cell(inout logic unf);
        if (depth_now == 0)
        begin
            unf = 1'b1;
            return '0;
        end
        depth_now--;
        return stack_words[depth_now];
    endfunction

    function automatic stack_result_t predict_stack_result(input cmd_t op,
                                                           input logic [DATA_W-1:0] lit);
        stack_result_t     r;
        logic [DATA_W-1:0] a, b, v, ma, mb, q;
        logic              unf, ovf, dz;
        unf = 1'b0;
        ovf = 1'b0;
        dz  = 1'b0;
        v   = '0;
        case (op)
            CMD_PUSH: push_cell(lit, ovf);
            CMD_DUP:
            begin
                a = pop_cell(unf);
                push_cell(a, ovf);
                push_cell(a, ovf);
            end
            CMD_SWAP:
            begin
                if (depth_now < 2)
                    unf = 1'b1;
                else
                begin
                    a = stack_words[depth_now-1];
                    stack_words[depth_now-1] = stack_words[depth_now-2];
                    stack_words[depth_now-2] = a;
                end
            end
            CMD_DROP: a = pop_cell(unf);
            CMD_PICK:
            begin
                a = pop_cell(unf);
                // negative or too deep index: flag it, the index stays popped
                if (a[DATA_W-1] || a >= DATA_W'(depth_now))
                    unf = 1'b1;
                else
                    push_cell(stack_words[depth_now - 1 - int'(a[31:0])], ovf);
            end
            CMD_NOP: ;
            default:
            begin
                b = pop_cell(unf);
                a = pop_cell(unf);
                case (op)
                    CMD_ADD: v = a + b;
                    CMD_SUB: v = a - b;
                    CMD_MUL: v = a * b;
                    CMD_DIV:
                    begin
                        if (b == '0)
                            dz = 1'b1;
                        else
                        begin
                            ma = a[DATA_W-1] ? -a : a;
                            mb = b[DATA_W-1] ? -b : b;
                            q  = ma / mb;
                            v  = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
                        end
                    end
                    CMD_GT:  v = DATA_W'($signed(a) >  $signed(b));
                    CMD_GE:  v = DATA_W'($signed(a) >= $signed(b));
                    CMD_LT:  v = DATA_W'($signed(a) <  $signed(b));
                    CMD_LE:  v = DATA_W'($signed(a) <= $signed(b));
                    CMD_EQ:  v = DATA_W'(a == b);
                    default: v = DATA_W'(a != b);
                endcase
                push_cell(v, ovf);
            end
        endcase
        r.top   = (depth_now != 0) ? stack_words[depth_now-1] : '0;
        r.depth = DEPTH_W'(depth_now);
        r.unf   = unf;
        r.ovf   = ovf;
        r.dz    = dz;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_now  = 0;
            mismatches = 0;
            awaited_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_results.push_back(
                    predict_stack_result(cmd_t'(s_tdata[CMD_W-1:0]), s_tdata[CMD_W +: DATA_W]));
            if (m_tvalid && m_tready)
            begin
                got.top   = m_tdata[DATA_W-1:0];
                got.depth = m_tdata[DATA_W +: DEPTH_W];
                got.unf   = m_tdata[DATA_W+DEPTH_W];
                got.ovf   = m_tdata[DATA_W+DEPTH_W+1];
                got.dz    = m_tdata[DATA_W+DEPTH_W+2];
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t stack check: unexpected word, top %h depth %0d",
                                 $realtime, got.top, got.depth);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.top !== want.top || got.depth !== want.depth ||
                        got.unf !== want.unf || got.ovf !== want.ovf || got.dz !== want.dz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t stack check: top exp %h got %h,",
                                   $realtime, want.top, got.top);
                            $display(" depth exp %0d got %0d, uf/of/dz exp %b%b%b got %b%b%b",
                                     want.depth, got.depth,
                                     want.unf, want.ovf, want.dz, got.unf, got.ovf, got.dz);
                        end
                    end
                end
            end
            fail_count <= mismatches;
            pending    <= awaited_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the forth_data_stack_alu testbench: clock, reset, command stimulus and verdict.
// Depends on fdsa_pkg, forth_data_stack_alu and stack_result_checker.
module tb;
    import fdsa_pkg::*;

    localparam int RANDOM_WORDS = 1600;   // random part, on top of the directed words
    localparam int CALM_WORDS   = 250;    // tail of the run with no idling at all
    localparam int HOLD_AT      = 500;    // word count at which the sink holds off
    localparam int DRAIN_AT     = 900;    // word count at which the source waits for drain
    localparam int LONG_HOLD    = 400;    // cycles of the long sink hold-off
    localparam int SETTLE       = 100;    // quiet cycles after the last result
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake before giving up

    localparam logic [DATA_W-1:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_S64 = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] NEG_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // cmd[3:0], literal[67:4], zero pad
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // top_value[63:0], depth[68:64], underflow, overflow, divide_by_zero
    logic [M_TDATA_W-1:0]  m_tdata;
    int unsigned           fail_count;
    int unsigned           pending;

    int unsigned words_sent    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned hold_requests = 0;
    bit          calm          = 1'b0;

    cmd_t binary_ops [11] = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_GE,
                              CMD_LT, CMD_LE, CMD_EQ, CMD_NE, CMD_ADD};

    wire any_handshake = (s_tvalid && s_tready) || (m_tvalid && m_tready);

    forth_data_stack_alu dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    stack_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Literal mix: small signed values so that pick and compare see meaningful
    // operands, full-width noise as often, plus extremes and mid-size values.
    function automatic logic [DATA_W-1:0] draw_literal();
        int k;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return MAX_S64;
                    1:       return MIN_S64;
                    2:       return NEG_ONE;
                    3:       return '0;
                    default: return 64'd1;
                endcase
            end
            1, 2, 3, 4:
            begin
                k = int'($urandom_range(0, 40)) - 20;
                return DATA_W'(longint'(k));
            end
            5:       return {$urandom, $urandom} >> $urandom_range(1, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one command word and hold it until the block takes it. An idle
    // burst may come first; valid stays high between back-to-back words.
    task automatic send_word(input cmd_t op, input logic [DATA_W-1:0] lit);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tdata  <= {{(S_TDATA_W - CMD_W - DATA_W){1'b0}}, lit, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Sink side: random ready bursts, a long hold-off on request, and no
    // back-pressure at all once the run turns calm.
    initial
    begin : sink
        int unsigned holds_served;
        int unsigned stall_pct;
        holds_served = 0;
        stall_pct    = 30;
        m_tready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end
            if (hold_requests != holds_served)
            begin
                // hold off long enough that the block backs up into its input
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Give up when no word moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if (any_handshake)
                stalled = 0;
            else
                stalled++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned      pick;
        int unsigned      total_words;
        int               k;
        bit               hold_issued;
        bit               drain_issued;
        cmd_t             op;
        logic [DATA_W-1:0] b;

        hold_issued  = 1'b0;
        drain_issued = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-stack pops, dup of nothing, swap with too few
        // entries, wraps at the signed extremes, divide by zero and the
        // most negative value over minus one, every compare, the last three with a
        // missing operand, pick in range, too deep and negative, and nop.
        send_word(CMD_DROP, MAX_S64);
        send_word(CMD_DUP,  MIN_S64);
        send_word(CMD_SWAP, '0);
        send_word(CMD_ADD,  NEG_ONE);
        send_word(CMD_SWAP, '0);
        send_word(CMD_PUSH, MAX_S64);
        send_word(CMD_PUSH, 64'd1);
        send_word(CMD_ADD,  '0);
        send_word(CMD_PUSH, NEG_ONE);
        send_word(CMD_DIV,  '0);
        send_word(CMD_PUSH, '0);
        send_word(CMD_DIV,  '0);
        send_word(CMD_PUSH, MIN_S64);
        send_word(CMD_PUSH, 64'd3);
        send_word(CMD_MUL,  '0);
        send_word(CMD_PUSH, 64'd5);
        send_word(CMD_SUB,  '0);
        send_word(CMD_GT,   '0);
        send_word(CMD_PUSH, NEG_ONE);
        send_word(CMD_GE,   '0);
        send_word(CMD_LT,   '0);
        send_word(CMD_LE,   '0);
        send_word(CMD_EQ,   '0);
        send_word(CMD_NE,   '0);
        send_word(CMD_PUSH, 64'd2);
        send_word(CMD_PICK, '0);
        send_word(CMD_PUSH, '0);
        send_word(CMD_PICK, '0);
        send_word(CMD_PUSH, NEG_ONE);
        send_word(CMD_PICK, '0);
        send_word(CMD_NOP,  MAX_S64);

        total_words = words_sent + RANDOM_WORDS;
        send_idle_pct = 15;

        // Random part: operand pairs feeding an operator, pick with a small
        // index, fills past the top, drains past the bottom, dup/swap runs and
        // raw noise over every code and literal bit.
        while (words_sent < total_words)
        begin
            if (words_sent + CALM_WORDS >= total_words)
                calm = 1'b1;
            if (calm)
                send_idle_pct = 0;
            else if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 15;
                    default: send_idle_pct = 50;
                endcase
            end

            if (!hold_issued && words_sent >= HOLD_AT)
            begin
                // sink holds off while the source keeps offering words
                hold_issued = 1'b1;
                hold_requests++;
            end
            if (!drain_issued && words_sent >= DRAIN_AT)
            begin
                // pause the source until every result is back
                drain_issued = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 32)
            begin
                op = binary_ops[$urandom_range(0, 10)];
                b  = draw_literal();
                if (op == CMD_DIV && $urandom_range(0, 3) == 0)
                    b = ($urandom_range(0, 1) != 0) ? '0 : NEG_ONE;
                send_word(CMD_PUSH, draw_literal());
                send_word(CMD_PUSH, b);
                send_word(op, draw_literal());
            end
            else if (pick < 44)
            begin
                k = int'($urandom_range(0, 21)) - 3;
                if ($urandom_range(0, 9) == 0)
                    send_word(CMD_PUSH, draw_literal());
                else
                    send_word(CMD_PUSH, DATA_W'(longint'(k)));
                send_word(CMD_PICK, draw_literal());
            end
            else if (pick < 52)
            begin
                repeat ($urandom_range(12, 18)) send_word(CMD_PUSH, draw_literal());
            end
            else if (pick < 60)
            begin
                repeat ($urandom_range(4, 18)) send_word(CMD_DROP, draw_literal());
            end
            else if (pick < 68)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(($urandom_range(0, 1) != 0) ? CMD_DUP : CMD_SWAP, draw_literal());
            end
            else
                send_word(cmd_t'(CMD_W'($urandom_range(0, 15))), draw_literal());
        end

        // Drop valid, wait out the remaining results, then let the block settle.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
